@@ hdl/nearest_ready_point_picker_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the nearest ready point picker
// Implication checks on clock, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef NEAREST_READY_POINT_PICKER_CORE_ASSERT_SVH
`define NEAREST_READY_POINT_PICKER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define NRPP_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define NRPP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define NRPP_ASSERT_IMPLY(label, ante, cons, msg)
`define NRPP_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

@@ hdl/nrpp_pkg.sv @@
// ----------------------------------------------------------------------------
// nrpp_pkg
// Sizes, codes and shared types of the nearest ready point picker.
// ----------------------------------------------------------------------------
`default_nettype none

package nrpp_pkg;

   localparam int TABLE_DEPTH = 32;
   localparam int COORD_BITS  = 8;

   localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
   localparam int SLOT_BITS   = 5;
   localparam int LIMIT_BITS  = 17;
   localparam int LIMIT_RESET = 50000;
   localparam int DIST_BITS   = 2 * COORD_BITS + 2;
   localparam int BEST_BITS   = (DIST_BITS > LIMIT_BITS) ? DIST_BITS : LIMIT_BITS;

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   typedef struct packed {
      logic                live;
      logic                ready;
      logic                last;
      logic [IDX_BITS-1:0] idx;
   } probe_type;

   typedef struct packed {
      logic                         live;
      logic                         ready;
      logic                         last;
      logic [IDX_BITS-1:0]          idx;
      logic signed [COORD_BITS-1:0] px;
      logic signed [COORD_BITS-1:0] py;
      logic [DIST_BITS-1:0]         sq_dist;
   } dist_res_type;

endpackage

`default_nettype wire

@@ hdl/nearest_ready_point_picker_core.sv @@
// ----------------------------------------------------------------------------
// nearest_ready_point_picker_core
// Point table with ready marks; a query picks the nearest ready point within
// the distance limit, clears its mark and returns goal and setpoints.
// ----------------------------------------------------------------------------
// Load word: accepted back to back, no response.
// Query word: the sequencer walks all TABLE_DEPTH entries through the shared
//   distance unit, one per cycle; the response word is registered in ST_FINISH
//   once the output is free, and the next word is taken back in ST_IDLE.
// Reset clears all ready marks and sets the limit to 50000; table contents
//   stay undefined until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

`include "nearest_ready_point_picker_core_assert.svh"

module nearest_ready_point_picker_core
   import nrpp_pkg::*;
(
   input  wire logic                         clock,
   input  wire logic                         reset,

   input  wire logic                         csr_wr_en,
   input  wire logic [LIMIT_BITS-1:0]        csr_wr_data,

   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic                         req_kind,
   input  wire logic [SLOT_BITS-1:0]         req_slot,
   input  wire logic signed [COORD_BITS-1:0] req_point_x,
   input  wire logic signed [COORD_BITS-1:0] req_point_y,
   input  wire logic signed [COORD_BITS-1:0] req_here_x,
   input  wire logic signed [COORD_BITS-1:0] req_here_y,

   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic                              rsp_found,
   output logic [SLOT_BITS-1:0]              rsp_chosen_slot,
   output logic signed [COORD_BITS-1:0]      rsp_goal_x,
   output logic signed [COORD_BITS:0]        rsp_goal_y,
   output logic signed [COORD_BITS:0]        rsp_setpoint_a,
   output logic signed [COORD_BITS:0]        rsp_setpoint_b
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WAIT,
      ST_FINISH
   } state_type;

   localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(TABLE_DEPTH - 1);

   state_type                    state_ff, state_in;
   logic [LIMIT_BITS-1:0]        limit_ff, limit_in;
   logic [TABLE_DEPTH-1:0]       ready_ff, ready_in;
   logic [IDX_BITS-1:0]          cnt_ff, cnt_in;
   probe_type                    probe_ff, probe_in;
   logic [BEST_BITS-1:0]         best_d_ff, best_d_in;
   logic                         hit_ff, hit_in;
   logic [IDX_BITS-1:0]          best_idx_ff, best_idx_in;
   logic signed [COORD_BITS-1:0] best_x_ff, best_x_in;
   logic signed [COORD_BITS-1:0] best_y_ff, best_y_in;
   logic signed [COORD_BITS-1:0] here_x_ff, here_x_in;
   logic signed [COORD_BITS-1:0] here_y_ff, here_y_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         found_ff, found_in;
   logic [SLOT_BITS-1:0]         chosen_ff, chosen_in;
   logic signed [COORD_BITS-1:0] goal_x_ff, goal_x_in;
   logic signed [COORD_BITS:0]   goal_y_ff, goal_y_in;
   logic signed [COORD_BITS:0]   set_a_ff, set_a_in;
   logic signed [COORD_BITS:0]   set_b_ff, set_b_in;

   logic                         req_accept;
   logic                         slot_ok;
   logic                         ram_wr_en;
   logic [2*COORD_BITS-1:0]      ram_rd_data;
   dist_res_type                 dist_res;
   logic                         fin_go;
   logic signed [COORD_BITS-1:0] fin_gx;
   logic signed [COORD_BITS:0]   fin_gy;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign slot_ok    = (32'(req_slot) < TABLE_DEPTH);
   assign ram_wr_en  = req_accept && (req_kind == KIND_LOAD) && slot_ok;
   assign fin_go     = !rsp_valid_ff || !rsp_stall;

   nrpp_ram #(
      .WIDTH (2 * COORD_BITS),
      .DEPTH (TABLE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (IDX_BITS'(req_slot)),
      .wr_data ({req_point_y, req_point_x}),
      .rd_addr (cnt_ff),
      .rd_data (ram_rd_data)
   );

   nrpp_dist_unit u_dist (
      .clock   (clock),
      .reset   (reset),
      .probe   (probe_ff),
      .point_x (ram_rd_data[COORD_BITS-1:0]),
      .point_y (ram_rd_data[2*COORD_BITS-1:COORD_BITS]),
      .here_x  (here_x_ff),
      .here_y  (here_y_ff),
      .res     (dist_res)
   );

   always_comb begin
      state_in     = state_ff;
      limit_in     = limit_ff;
      ready_in     = ready_ff;
      cnt_in       = cnt_ff;
      probe_in     = '0;
      best_d_in    = best_d_ff;
      hit_in       = hit_ff;
      best_idx_in  = best_idx_ff;
      best_x_in    = best_x_ff;
      best_y_in    = best_y_ff;
      here_x_in    = here_x_ff;
      here_y_in    = here_y_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      found_in     = found_ff;
      chosen_in    = chosen_ff;
      goal_x_in    = goal_x_ff;
      goal_y_in    = goal_y_ff;
      set_a_in     = set_a_ff;
      set_b_in     = set_b_ff;

      fin_gx = hit_ff ? best_x_ff : '0;
      fin_gy = hit_ff ? ((COORD_BITS+1)'(best_y_ff) - (COORD_BITS+1)'(1)) : '0;

      if (csr_wr_en) begin
         limit_in = csr_wr_data;
      end

      if (dist_res.live && dist_res.ready && (BEST_BITS'(dist_res.sq_dist) < best_d_ff)) begin
         best_d_in   = BEST_BITS'(dist_res.sq_dist);
         hit_in      = 1'b1;
         best_idx_in = dist_res.idx;
         best_x_in   = dist_res.px;
         best_y_in   = dist_res.py;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_kind == KIND_LOAD) begin
                  if (slot_ok) begin
                     ready_in[IDX_BITS'(req_slot)] = 1'b1;
                  end
               end else begin
                  state_in    = ST_SCAN;
                  cnt_in      = '0;
                  best_d_in   = BEST_BITS'(limit_ff);
                  hit_in      = 1'b0;
                  best_idx_in = '0;
                  here_x_in   = req_here_x;
                  here_y_in   = req_here_y;
               end
            end
         end
         ST_SCAN: begin
            probe_in.live  = 1'b1;
            probe_in.ready = ready_ff[cnt_ff];
            probe_in.last  = (cnt_ff == LAST_IDX);
            probe_in.idx   = cnt_ff;
            cnt_in         = cnt_ff + 1'b1;
            if (cnt_ff == LAST_IDX) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (dist_res.live && dist_res.last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (fin_go) begin
               rsp_valid_in = 1'b1;
               found_in     = hit_ff;
               chosen_in    = SLOT_BITS'(best_idx_ff);
               goal_x_in    = fin_gx;
               goal_y_in    = fin_gy;
               set_a_in     = fin_gy - (COORD_BITS+1)'(here_y_ff);
               set_b_in     = (COORD_BITS+1)'(fin_gx) - (COORD_BITS+1)'(here_x_ff);
               if (hit_ff) begin
                  ready_in[best_idx_ff] = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         limit_ff     <= LIMIT_BITS'(LIMIT_RESET);
         ready_ff     <= '0;
         cnt_ff       <= '0;
         probe_ff     <= '0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         limit_ff     <= limit_in;
         ready_ff     <= ready_in;
         cnt_ff       <= cnt_in;
         probe_ff     <= probe_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      best_d_ff   <= best_d_in;
      best_idx_ff <= best_idx_in;
      best_x_ff   <= best_x_in;
      best_y_ff   <= best_y_in;
      here_x_ff   <= here_x_in;
      here_y_ff   <= here_y_in;
      found_ff    <= found_in;
      chosen_ff   <= chosen_in;
      goal_x_ff   <= goal_x_in;
      goal_y_ff   <= goal_y_in;
      set_a_ff    <= set_a_in;
      set_b_ff    <= set_b_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = found_ff;
   assign rsp_chosen_slot = chosen_ff;
   assign rsp_goal_x      = goal_x_ff;
   assign rsp_goal_y      = goal_y_ff;
   assign rsp_setpoint_a  = set_a_ff;
   assign rsp_setpoint_b  = set_b_ff;

   `NRPP_ASSERT_NEXT(a_mark_cleared, (state_ff == ST_FINISH && fin_go && hit_ff), !ready_ff[$past(best_idx_ff)], "chosen point still marked ready")
   `NRPP_ASSERT_IMPLY(a_miss_zero, (rsp_valid_ff && !found_ff), (chosen_ff == '0 && goal_x_ff == '0 && goal_y_ff == '0), "miss word carries nonzero slot or goal")
   `NRPP_ASSERT_IMPLY(a_dist_in_scan, dist_res.live, (state_ff == ST_SCAN || state_ff == ST_WAIT), "distance result outside scan")
   `NRPP_ASSERT_IMPLY(a_rsp_from_finish, $rose(rsp_valid_ff), ($past(state_ff) == ST_FINISH), "response word raised outside finish")

endmodule

`default_nettype wire

@@ hdl/nrpp_ram.sv @@
// ----------------------------------------------------------------------------
// nrpp_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module nrpp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

@@ hdl/nrpp_dist_unit.sv @@
// ----------------------------------------------------------------------------
// nrpp_dist_unit
// Shared squared distance unit: one table entry per cycle, registered result.
// ----------------------------------------------------------------------------
`default_nettype none

module nrpp_dist_unit
   import nrpp_pkg::*;
(
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire probe_type                    probe,
   input  wire logic signed [COORD_BITS-1:0] point_x,
   input  wire logic signed [COORD_BITS-1:0] point_y,
   input  wire logic signed [COORD_BITS-1:0] here_x,
   input  wire logic signed [COORD_BITS-1:0] here_y,
   output dist_res_type                      res
);

   logic signed [COORD_BITS:0]     dx;
   logic signed [COORD_BITS:0]     dy;
   logic signed [2*COORD_BITS+1:0] sq_x;
   logic signed [2*COORD_BITS+1:0] sq_y;
   dist_res_type                   res_in;
   dist_res_type                   res_ff;

   always_comb begin
      dx   = (COORD_BITS+1)'(point_x) - (COORD_BITS+1)'(here_x);
      dy   = (COORD_BITS+1)'(point_y) - (COORD_BITS+1)'(here_y);
      sq_x = dx * dx;
      sq_y = dy * dy;

      res_in.live    = probe.live;
      res_in.ready   = probe.ready;
      res_in.last    = probe.last;
      res_in.idx     = probe.idx;
      res_in.px      = point_x;
      res_in.py      = point_y;
      res_in.sq_dist = DIST_BITS'($unsigned(sq_x)) + DIST_BITS'($unsigned(sq_y));
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
      if (reset) begin
         res_ff.live <= 1'b0;
      end
   end

   assign res = res_ff;

endmodule

`default_nettype wire
